[sv/c2s_pkg.sv]
// Shared constants, types and helpers for the cube-to-sphere point map.
// Used by cube_to_sphere_point_map_core; depends on nothing else.
package c2s_pkg;

  // Coordinate and magnitude widths (magnitude holds 2^(CW-1))
  localparam int unsigned CW = 32;
  localparam int unsigned MW = CW;
  // Q30 fractions reach exactly 1.0, so they need 31 bits
  localparam int unsigned QW = 31;
  // Square root radicand: Q30 term shifted up by 30
  localparam int unsigned RW = 2 * QW - 1;
  // Mapped magnitude before saturation
  localparam int unsigned OW = CW + 2;

  localparam int unsigned NCOORD      = 3;
  localparam int unsigned DIV_LANES   = 4;
  localparam int unsigned DIV_STAGES  = QW;
  localparam int unsigned SQRT_STAGES = QW;

  localparam logic [QW-1:0] Q_ONE    = 31'h4000_0000;
  // floor(sqrt(2^60 / 3)): 1/sqrt(3) in Q30
  localparam logic [QW-1:0] K3       = 31'd619925131;
  // floor(x / 3) = (x * RECIP3) >> 33 for any 32-bit x
  localparam logic [31:0]   RECIP3   = 32'hAAAA_AAAB;
  localparam logic [16:0]   FLAT_ONE = 17'h1_0000;

  typedef enum logic [2:0] {
    REGION_ORIGIN   = 3'd0,
    REGION_INNER    = 3'd1,
    REGION_CORE     = 3'd2,
    REGION_ENVELOPE = 3'd3,
    REGION_OUTSIDE  = 3'd4
  } region_e;

  typedef enum logic [1:0] {
    CFG_CORE_RADIUS = 2'd0,
    CFG_STAR_RADIUS = 2'd1,
    CFG_FLATTENING  = 2'd2,
    CFG_MULTI_BLOCK = 2'd3
  } cfg_idx_e;

  // Per-item data that travels down the pipeline; later fields fill in as it goes
  typedef struct packed {
    logic [NCOORD-1:0]          neg;
    logic [NCOORD-1:0][MW-1:0]  mag;
    logic [MW-1:0]              m;
    region_e                    region;
    logic [NCOORD-1:0][QW-1:0]  p;
    logic [QW-1:0]              t;
    logic [NCOORD-1:0][QW-1:0]  bl;
  } item_t;

  // Round half up after dropping 30 fraction bits
  function automatic logic [63:0] rnd_q30(input logic [63:0] prod);
    return (prod + 64'h2000_0000) >> 30;
  endfunction

endpackage

[sv/cube_to_sphere_point_map_core.sv]
// Pipelined cube-to-sphere (spherified cube) point map, top level.
// Depends on c2s_pkg for widths, constants, region codes and the item struct.

// Accepts one point per cycle while the output is not stalled and returns one
// mapped point per point: two front stages (magnitudes, max and region), a
// 31-stage restoring divider for the Q30 direction cosines, four stages of
// squares and products, a 31-stage bit-per-stage square root, four stages of
// scaling and flattening and the output register. The whole pipeline advances
// together and holds while a finished point waits at the output. Configuration
// registers feed the stages directly, so a write also affects points already in
// flight; cfg_ready_o is always high.
module cube_to_sphere_point_map_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Point input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [c2s_pkg::CW-1:0] in_x_i,
  input  logic signed [c2s_pkg::CW-1:0] in_y_i,
  input  logic signed [c2s_pkg::CW-1:0] in_z_i,
  // Mapped point output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [c2s_pkg::CW-1:0] out_x_o,
  output logic signed [c2s_pkg::CW-1:0] out_y_o,
  output logic signed [c2s_pkg::CW-1:0] out_z_o,
  output logic [2:0]                  region_o,
  // Configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  localparam int unsigned CW  = c2s_pkg::CW;
  localparam int unsigned MW  = c2s_pkg::MW;
  localparam int unsigned QW  = c2s_pkg::QW;
  localparam int unsigned RW  = c2s_pkg::RW;
  localparam int unsigned OW  = c2s_pkg::OW;
  localparam int unsigned NC  = c2s_pkg::NCOORD;
  localparam int unsigned NL  = c2s_pkg::DIV_LANES;
  localparam int unsigned NDV = c2s_pkg::DIV_STAGES;
  localparam int unsigned NSQ = c2s_pkg::SQRT_STAGES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [30:0] cfg_core_q;
  logic [30:0] cfg_star_q;
  logic [15:0] cfg_flat_q;
  logic        cfg_mb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_core_q <= 31'd65536;
      cfg_star_q <= 31'd131072;
      cfg_flat_q <= 16'd0;
      cfg_mb_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        c2s_pkg::CFG_CORE_RADIUS: cfg_core_q <= cfg_data_i[30:0];
        c2s_pkg::CFG_STAR_RADIUS: cfg_star_q <= cfg_data_i[30:0];
        c2s_pkg::CFG_FLATTENING:  cfg_flat_q <= cfg_data_i[15:0];
        c2s_pkg::CFG_MULTI_BLOCK: cfg_mb_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Scaled cube radius core/(2*sqrt(3)), refreshed every cycle from the register
  logic [QW-1:0] sc_q;
  logic [61:0]   sc_prod;

  assign sc_prod = cfg_core_q * c2s_pkg::K3;

  always_ff @(posedge clk_i) begin
    sc_q <= QW'((64'(sc_prod) + 64'h4000_0000) >> 31);
  end

  // ---------------------------------------------------------------------------
  // Global advance: hold everything while the output item is stalled
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Stage A: signs and magnitudes
  logic            a_v_q;
  c2s_pkg::item_t  a_q, a_d;
  logic [CW-1:0]   in_c [NC];

  assign in_c[0] = in_x_i;
  assign in_c[1] = in_y_i;
  assign in_c[2] = in_z_i;

  always_comb begin
    a_d = '0;
    for (int i = 0; i < NC; i++) begin
      a_d.neg[i] = in_c[i][CW-1];
      a_d.mag[i] = in_c[i][CW-1] ? (~in_c[i] + CW'(1)) : in_c[i];
    end
  end

  // Stage B: largest magnitude and region
  logic            b_v_q;
  c2s_pkg::item_t  b_q, b_d;
  logic [MW-1:0]   b_m;
  logic [MW:0]     b_core_x2;

  always_comb begin
    b_m = a_q.mag[0];
    if (a_q.mag[1] > b_m) b_m = a_q.mag[1];
    if (a_q.mag[2] > b_m) b_m = a_q.mag[2];
    b_core_x2 = {2'b00, cfg_core_q};
    b_d   = a_q;
    b_d.m = b_m;
    if (!cfg_mb_q && b_m == '0) begin
      b_d.region = c2s_pkg::REGION_ORIGIN;
    end else if (cfg_mb_q && {b_m, 1'b0} <= b_core_x2) begin
      b_d.region = c2s_pkg::REGION_INNER;
    end else if (b_m <= {1'b0, cfg_core_q}) begin
      b_d.region = c2s_pkg::REGION_CORE;
    end else if (b_m <= {1'b0, cfg_star_q}) begin
      b_d.region = c2s_pkg::REGION_ENVELOPE;
    end else begin
      b_d.region = c2s_pkg::REGION_OUTSIDE;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: lanes 0..2 give a/m (or a/core in the single-mode core), lane 3
  // gives the blend weight (2m - core)/core; one quotient bit per stage
  logic [NDV-1:0]  dv_q;
  c2s_pkg::item_t  di_q [NDV];
  logic [MW-1:0]   dd_q [NDV];
  logic [MW-1:0]   dr_q [NDV][NL];
  logic [QW-1:0]   dq_q [NDV][NL];

  // First stage: integer quotient bit
  logic [MW-1:0]   d0_den;
  logic [MW-1:0]   d0_n [NL];
  logic [MW-1:0]   d0_d [NL];
  logic [NL-1:0]   d0_ge;
  logic [MW:0]     d0_nt;

  always_comb begin
    d0_den = (b_q.region == c2s_pkg::REGION_CORE && !cfg_mb_q) ?
             {1'b0, cfg_core_q} : b_q.m;
    d0_nt  = {b_q.m, 1'b0} - {2'b00, cfg_core_q};
    for (int l = 0; l < NL; l++) begin
      if (l < NC) begin
        d0_n[l] = b_q.mag[l];
        d0_d[l] = d0_den;
      end else begin
        d0_n[l] = d0_nt[MW-1:0];
        d0_d[l] = {1'b0, cfg_core_q};
      end
      d0_ge[l] = d0_n[l] >= d0_d[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      di_q[0] <= b_q;
      dd_q[0] <= d0_den;
      for (int l = 0; l < NL; l++) begin
        dr_q[0][l] <= d0_ge[l] ? (d0_n[l] - d0_d[l]) : d0_n[l];
        dq_q[0][l] <= {{(QW-1){1'b0}}, d0_ge[l]};
      end
    end
  end

  // Fraction stages: shift, compare, subtract
  for (genvar k = 1; k < NDV; k++) begin : g_div
    logic [NL-1:0] ge;
    logic [MW:0]   rn [NL];

    always_comb begin
      logic [MW:0]   r2;
      logic [MW-1:0] dl;
      for (int l = 0; l < NL; l++) begin
        dl    = (l < NC) ? dd_q[k-1] : {1'b0, cfg_core_q};
        r2    = {dr_q[k-1][l], 1'b0};
        ge[l] = r2 >= {1'b0, dl};
        rn[l] = ge[l] ? (r2 - {1'b0, dl}) : r2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        di_q[k] <= di_q[k-1];
        dd_q[k] <= dd_q[k-1];
        for (int l = 0; l < NL; l++) begin
          dr_q[k][l] <= rn[l][MW-1:0];
          dq_q[k][l] <= {dq_q[k-1][l][QW-2:0], ge[l]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // E1: squares of the direction values and cube-side blend factor
  logic            e1_v_q;
  c2s_pkg::item_t  e1_q, e1_d;
  logic [QW-1:0]   e1_sq_q [NC];
  logic [QW-1:0]   e1_u_q  [NC];
  logic [QW-1:0]   e1_sq_d [NC];
  logic [QW-1:0]   e1_u_d  [NC];

  always_comb begin
    logic [2*QW-1:0] psq;
    logic [2*QW-1:0] pu;
    e1_d   = di_q[NDV-1];
    e1_d.t = dq_q[NDV-1][NL-1];
    for (int i = 0; i < NC; i++) begin
      e1_d.p[i]  = dq_q[NDV-1][i];
      psq        = dq_q[NDV-1][i] * dq_q[NDV-1][i];
      pu         = dq_q[NDV-1][i] * (c2s_pkg::Q_ONE - dq_q[NDV-1][NL-1]);
      e1_sq_d[i] = QW'(c2s_pkg::rnd_q30(64'(psq)));
      e1_u_d[i]  = QW'(c2s_pkg::rnd_q30(64'(pu)));
    end
  end

  // E2: cross products of squares, cube-side blend term
  logic            e2_v_q;
  c2s_pkg::item_t  e2_q, e2_d;
  logic [QW-1:0]   e2_sq_q [NC];
  logic [QW-1:0]   e2_pr_q [NC];
  logic [QW-1:0]   e2_pr_d [NC];

  always_comb begin
    logic [1:0]      ja;
    logic [1:0]      jb;
    logic [2*QW-1:0] pp;
    logic [2*QW-1:0] pb;
    e2_d = e1_q;
    for (int i = 0; i < NC; i++) begin
      ja         = (i == 0) ? 2'd1 : 2'd0;
      jb         = (i == 2) ? 2'd1 : 2'd2;
      pp         = e1_sq_q[ja] * e1_sq_q[jb];
      pb         = e1_u_q[i] * sc_q;
      e2_pr_d[i] = QW'(c2s_pkg::rnd_q30(64'(pp)));
      e2_d.bl[i] = QW'(c2s_pkg::rnd_q30(64'(pb)));
    end
  end

  // E3: third of the cross product by reciprocal multiply
  logic            e3_v_q;
  c2s_pkg::item_t  e3_q;
  logic [QW-1:0]   e3_sq_q [NC];
  logic [QW-1:0]   e3_d3_q [NC];
  logic [QW-1:0]   e3_d3_d [NC];

  always_comb begin
    logic [63:0] pr3;
    for (int i = 0; i < NC; i++) begin
      pr3        = {1'b0, e2_pr_q[i]} * c2s_pkg::RECIP3;
      e3_d3_d[i] = QW'(pr3 >> 33);
    end
  end

  // E4: spherify term under the root
  logic            e4_v_q;
  c2s_pkg::item_t  e4_q;
  logic [QW-1:0]   e4_term_q [NC];
  logic [QW-1:0]   e4_term_d [NC];

  always_comb begin
    logic [1:0] ja;
    logic [1:0] jb;
    for (int i = 0; i < NC; i++) begin
      ja           = (i == 0) ? 2'd1 : 2'd0;
      jb           = (i == 2) ? 2'd1 : 2'd2;
      e4_term_d[i] = c2s_pkg::Q_ONE - (e3_sq_q[ja] >> 1) - (e3_sq_q[jb] >> 1)
                     + e3_d3_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
      e4_v_q <= 1'b0;
    end else if (en) begin
      a_v_q  <= in_valid_i;
      b_v_q  <= a_v_q;
      e1_v_q <= dv_q[NDV-1];
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
      e4_v_q <= e3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= a_d;
      b_q  <= b_d;
      e1_q <= e1_d;
      e2_q <= e2_d;
      e3_q <= e2_q;
      e4_q <= e3_q;
      for (int i = 0; i < NC; i++) begin
        e1_sq_q[i]   <= e1_sq_d[i];
        e1_u_q[i]    <= e1_u_d[i];
        e2_sq_q[i]   <= e1_sq_q[i];
        e2_pr_q[i]   <= e2_pr_d[i];
        e3_sq_q[i]   <= e2_sq_q[i];
        e3_d3_q[i]   <= e3_d3_d[i];
        e4_term_q[i] <= e4_term_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: one result bit per stage, most significant first
  logic [NSQ-1:0]  sv_q;
  c2s_pkg::item_t  si_q  [NSQ];
  logic [RW-1:0]   srm_q [NSQ][NC];
  logic [QW-1:0]   srs_q [NSQ][NC];

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int unsigned B = NSQ - 1 - j;

    logic            v_in;
    c2s_pkg::item_t  it_in;
    logic [RW-1:0]   rm_in [NC];
    logic [QW-1:0]   rs_in [NC];
    logic [RW-1:0]   rm_n  [NC];
    logic [QW-1:0]   rs_n  [NC];

    if (j == 0) begin : g_src
      assign v_in  = e4_v_q;
      assign it_in = e4_q;
      for (genvar i = 0; i < NC; i++) begin : g_lane
        assign rm_in[i] = {e4_term_q[i], {(RW-QW){1'b0}}};
        assign rs_in[i] = '0;
      end
    end else begin : g_src
      assign v_in  = sv_q[j-1];
      assign it_in = si_q[j-1];
      for (genvar i = 0; i < NC; i++) begin : g_lane
        assign rm_in[i] = srm_q[j-1][i];
        assign rs_in[i] = srs_q[j-1][i];
      end
    end

    always_comb begin
      logic [RW:0] cand;
      for (int i = 0; i < NC; i++) begin
        cand = ((RW+1)'(rs_in[i]) << (B + 1)) + ((RW+1)'(1) << (2 * B));
        if ({1'b0, rm_in[i]} >= cand) begin
          rm_n[i] = rm_in[i] - cand[RW-1:0];
          rs_n[i] = rs_in[i] | (QW'(1) << B);
        end else begin
          rm_n[i] = rm_in[i];
          rs_n[i] = rs_in[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j] <= 1'b0;
      end else if (en) begin
        sv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        si_q[j] <= it_in;
        for (int i = 0; i < NC; i++) begin
          srm_q[j][i] <= rm_n[i];
          srs_q[j][i] <= rs_n[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // F1: spherified component s = p * root
  logic            f1_v_q;
  c2s_pkg::item_t  f1_q;
  logic [QW-1:0]   f1_s_q [NC];
  logic [QW-1:0]   f1_s_d [NC];

  always_comb begin
    logic [2*QW-1:0] ps;
    for (int i = 0; i < NC; i++) begin
      ps        = si_q[NSQ-1].p[i] * srs_q[NSQ-1][i];
      f1_s_d[i] = QW'(c2s_pkg::rnd_q30(64'(ps)));
    end
  end

  // F2: region scaling multiply (one product per lane)
  logic            f2_v_q;
  c2s_pkg::item_t  f2_q;
  logic [MW-1:0]   f2_w_q [NC];
  logic [MW-1:0]   f2_w_d [NC];

  always_comb begin
    logic [MW-1:0]      op_a;
    logic [QW-1:0]      op_b;
    logic [MW+QW-1:0]   pw;
    for (int i = 0; i < NC; i++) begin
      case (f1_q.region) inside
        c2s_pkg::REGION_INNER: begin
          op_a = f1_q.mag[i];
          op_b = c2s_pkg::K3;
        end
        c2s_pkg::REGION_CORE: begin
          op_a = {1'b0, f1_s_q[i]};
          op_b = cfg_mb_q ? f1_q.t : cfg_core_q;
        end
        c2s_pkg::REGION_ENVELOPE, c2s_pkg::REGION_OUTSIDE: begin
          op_a = f1_q.m;
          op_b = f1_s_q[i];
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
      pw        = op_a * op_b;
      f2_w_d[i] = MW'(c2s_pkg::rnd_q30(64'(pw)));
    end
  end

  // F3: in the multi-block core region, sphere-side blend term times core radius plus cube-side term
  logic            f3_v_q;
  c2s_pkg::item_t  f3_q;
  logic [OW-1:0]   f3_o_q [NC];
  logic [OW-1:0]   f3_o_d [NC];

  always_comb begin
    logic [MW+QW-1:0] pc;
    for (int i = 0; i < NC; i++) begin
      pc = f2_w_q[i] * cfg_core_q;
      if (f2_q.region == c2s_pkg::REGION_CORE && cfg_mb_q) begin
        f3_o_d[i] = OW'(c2s_pkg::rnd_q30(64'(pc))) + OW'(f2_q.bl[i]);
      end else begin
        f3_o_d[i] = OW'(f2_w_q[i]);
      end
    end
  end

  // F4: flatten z (origin points pass through)
  logic            f4_v_q;
  c2s_pkg::item_t  f4_q;
  logic [OW-1:0]   f4_o_q [NC];
  logic [OW-1:0]   f4_o_d [NC];

  always_comb begin
    logic [16:0]    keep;
    logic [OW+16:0] pz;
    keep = c2s_pkg::FLAT_ONE - {1'b0, cfg_flat_q};
    pz   = f3_o_q[2] * keep;
    f4_o_d[0] = f3_o_q[0];
    f4_o_d[1] = f3_o_q[1];
    if (f3_q.region != c2s_pkg::REGION_ORIGIN) begin
      f4_o_d[2] = OW'((pz + (OW+17)'(17'h0_8000)) >> 16);
    end else begin
      f4_o_d[2] = f3_o_q[2];
    end
  end

  // Output register: saturate and restore signs
  logic [CW-1:0]    out_c_q [NC];
  logic [CW-1:0]    out_c_d [NC];
  c2s_pkg::region_e out_region_q;

  always_comb begin
    logic [OW-1:0] lim;
    logic [OW-1:0] mag_s;
    for (int i = 0; i < NC; i++) begin
      lim        = f4_q.neg[i] ? (OW'(1) << (CW - 1)) : ((OW'(1) << (CW - 1)) - OW'(1));
      mag_s      = (f4_o_q[i] > lim) ? lim : f4_o_q[i];
      out_c_d[i] = f4_q.neg[i] ? (CW'(0) - mag_s[CW-1:0]) : mag_s[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q      <= 1'b0;
      f2_v_q      <= 1'b0;
      f3_v_q      <= 1'b0;
      f4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      f1_v_q      <= sv_q[NSQ-1];
      f2_v_q      <= f1_v_q;
      f3_v_q      <= f2_v_q;
      f4_v_q      <= f3_v_q;
      out_valid_q <= f4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q         <= si_q[NSQ-1];
      f2_q         <= f1_q;
      f3_q         <= f2_q;
      f4_q         <= f3_q;
      out_region_q <= f4_q.region;
      for (int i = 0; i < NC; i++) begin
        f1_s_q[i]  <= f1_s_d[i];
        f2_w_q[i]  <= f2_w_d[i];
        f3_o_q[i]  <= f3_o_d[i];
        f4_o_q[i]  <= f4_o_d[i];
        out_c_q[i] <= out_c_d[i];
      end
    end
  end

  // Drive outputs
  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_c_q[0];
  assign out_y_o     = out_c_q[1];
  assign out_z_o     = out_c_q[2];
  assign region_o    = out_region_q;

endmodule
